FILE: hdl/trfd_pkg.sv
// ----------------------------------------------------------------------------
// trfd_pkg: test record frame deframer package
// Result type, push bundle, field codes and frame layout constants.
// ----------------------------------------------------------------------------
package trfd_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNC   = 2'd1;
	localparam logic [1:0] ST_LENGTH = 2'd2;
	localparam logic [1:0] ST_SHORT  = 2'd3;

	localparam logic [7:0] SYNC_EVEN = 8'hF7;
	localparam logic [7:0] SYNC_ODD  = 8'h7E;

	localparam int POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [POS_W-1:0] POS_SYNC_END = 17'd4;
	localparam logic [POS_W-1:0] POS_CODE     = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd5;
	localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd6;
	localparam logic [POS_W-1:0] POS_SRC      = 17'd7;
	localparam logic [POS_W-1:0] POS_DST      = 17'd8;
	localparam logic [POS_W-1:0] POS_CNT_END  = 17'd12;
	localparam logic [POS_W-1:0] POS_TIME_END = 17'd16;
	localparam logic [POS_W-1:0] POS_TABLE    = 17'd17;
	localparam logic [17:0]      LEN_OVERHEAD = 18'd21;

	localparam int REC_CNT_W = 14;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [7:0]  frame_id;
		logic [7:0]  src_node;
		logic [7:0]  dst_node;
		logic [31:0] frame_count;
		logic [31:0] time_stamp;
		logic [7:0]  table_number;
		logic [7:0]  coding;
		logic [31:0] value;
		logic [7:0]  pass_flag;
		logic [31:0] test_stamp;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: hdl/trfd_parser.sv
// ----------------------------------------------------------------------------
// trfd_parser: frame byte parser
// Tracks byte position, captures header and record fields, and produces up
// to two results for each accepted byte.
// ----------------------------------------------------------------------------
module trfd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      data_byte,
	input  logic            frame_last,
	output trfd_pkg::push_t push
);

	logic [16:0] pos_q, pos_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  fcode_q, fcode_n;
	logic [7:0]  src_q, src_n;
	logic [7:0]  dst_q, dst_n;
	logic [31:0] cnt_q, cnt_n;
	logic [31:0] time_q, time_n;
	logic [7:0]  tbl_q, tbl_n;
	logic [3:0]  rbi_q, rbi_n;
	logic [trfd_pkg::REC_CNT_W-1:0] pc_q, pc_n;
	logic [7:0]  coding_q, coding_n;
	logic [31:0] value_q, value_n;
	logic [7:0]  flag_q, flag_n;
	logic [31:0] ttime_q, ttime_n;
	logic        discard_q, discard_n;

	logic [3:0]  vb;
	logic [3:0]  rec_size;
	logic        tbl_known;
	logic [trfd_pkg::REC_CNT_W:0] pc_inc;
	logic [18:0] rec_prod;
	logic        rec_active;
	logic [1:0]  hdr_idx;
	logic [3:0]  vidx;
	logic [3:0]  tidx;
	logic        emit_hdr;
	logic        emit_rec;
	logic [1:0]  end_status;
	trfd_pkg::result_t base_res, hdr_res, rec_res, end_res;

	always_comb begin
		tbl_known = 1'b1;
		case (tbl_q)
			8'd1, 8'd2: vb = 4'd1;
			8'd3:       vb = 4'd4;
			8'd4:       vb = 4'd2;
			default: begin
				vb = 4'd0;
				tbl_known = 1'b0;
			end
		endcase
		rec_size = vb + 4'd6;
		pc_inc   = {1'b0, pc_q} + 1'b1;
		rec_prod = 19'(pc_inc) * 19'(rec_size);
		// (pc+1)*size <= len-1 is pc < floor((len-1)/size)
		rec_active = tbl_known ? (rec_prod < 19'(len_q)) : (pc_q == '0);
	end

	assign hdr_idx = pos_q[1:0] - 2'd1;
	assign vidx    = rbi_q - 4'd1;
	assign tidx    = rbi_q - vb - 4'd2;

	always_comb begin
		pos_n     = pos_q;
		len_n     = len_q;
		fcode_n   = fcode_q;
		src_n     = src_q;
		dst_n     = dst_q;
		cnt_n     = cnt_q;
		time_n    = time_q;
		tbl_n     = tbl_q;
		rbi_n     = rbi_q;
		pc_n      = pc_q;
		coding_n  = coding_q;
		value_n   = value_q;
		flag_n    = flag_q;
		ttime_n   = ttime_q;
		discard_n = discard_q;
		emit_hdr  = 1'b0;
		emit_rec  = 1'b0;

		if (pos_q < trfd_pkg::POS_SYNC_END) begin
			if (data_byte != (pos_q[0] ? trfd_pkg::SYNC_ODD : trfd_pkg::SYNC_EVEN))
				discard_n = 1'b1;
		end else if (pos_q == trfd_pkg::POS_CODE) begin
			fcode_n = data_byte;
		end else if (pos_q == trfd_pkg::POS_LEN_LO) begin
			len_n[7:0] = data_byte;
		end else if (pos_q == trfd_pkg::POS_LEN_HI) begin
			len_n[15:8] = data_byte;
		end else if (pos_q == trfd_pkg::POS_SRC) begin
			src_n = data_byte;
		end else if (pos_q == trfd_pkg::POS_DST) begin
			dst_n = data_byte;
		end else if (pos_q <= trfd_pkg::POS_CNT_END) begin
			cnt_n[8*hdr_idx +: 8] = data_byte;
		end else if (pos_q <= trfd_pkg::POS_TIME_END) begin
			time_n[8*hdr_idx +: 8] = data_byte;
		end else if (pos_q == trfd_pkg::POS_TABLE) begin
			tbl_n    = data_byte;
			emit_hdr = !discard_q;
		end else if (!discard_q && rec_active) begin
			if (rbi_q == 4'd0) begin
				coding_n = data_byte;
				value_n  = '0;
				flag_n   = '0;
				ttime_n  = '0;
			end else if (rbi_q <= vb) begin
				value_n[8*vidx[1:0] +: 8] = data_byte;
			end else if (rbi_q == vb + 4'd1) begin
				flag_n = data_byte;
			end else begin
				ttime_n[8*tidx[1:0] +: 8] = data_byte;
			end
			if (rbi_q >= vb + 4'd5) begin
				emit_rec = 1'b1;
				pc_n     = pc_inc[trfd_pkg::REC_CNT_W-1:0];
				rbi_n    = 4'd0;
			end else begin
				rbi_n = rbi_q + 4'd1;
			end
		end

		if (!frame_last && pos_q != trfd_pkg::POS_MAX)
			pos_n = pos_q + 17'd1;
	end

	always_comb begin
		if (discard_n)
			end_status = trfd_pkg::ST_SYNC;
		else if (pos_q < trfd_pkg::POS_TABLE)
			end_status = trfd_pkg::ST_SHORT;
		else if (18'(pos_q) + 18'd1 != 18'(len_n) + trfd_pkg::LEN_OVERHEAD)
			end_status = trfd_pkg::ST_LENGTH;
		else
			end_status = trfd_pkg::ST_OK;
	end

	always_comb begin
		base_res              = '0;
		base_res.frame_id     = fcode_n;
		base_res.src_node     = src_n;
		base_res.dst_node     = dst_n;
		base_res.frame_count  = cnt_n;
		base_res.time_stamp   = time_n;
		base_res.table_number = tbl_n;

		hdr_res      = base_res;
		hdr_res.kind = trfd_pkg::KIND_HEADER;

		rec_res            = base_res;
		rec_res.kind       = trfd_pkg::KIND_RECORD;
		rec_res.coding     = coding_n;
		rec_res.value      = value_n;
		rec_res.pass_flag  = flag_n;
		rec_res.test_stamp = ttime_n;

		end_res        = base_res;
		end_res.kind   = trfd_pkg::KIND_END;
		end_res.status = end_status;

		push.r1 = end_res;
		if (emit_hdr)
			push.r0 = hdr_res;
		else if (emit_rec)
			push.r0 = rec_res;
		else
			push.r0 = end_res;

		if (!fire)
			push.count = 2'd0;
		else
			push.count = 2'(emit_hdr | emit_rec) + 2'(frame_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			fcode_q   <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			cnt_q     <= '0;
			time_q    <= '0;
			tbl_q     <= '0;
			rbi_q     <= '0;
			pc_q      <= '0;
			coding_q  <= '0;
			value_q   <= '0;
			flag_q    <= '0;
			ttime_q   <= '0;
			discard_q <= 1'b0;
		end else if (fire) begin
			if (frame_last) begin
				pos_q     <= '0;
				len_q     <= '0;
				fcode_q   <= '0;
				src_q     <= '0;
				dst_q     <= '0;
				cnt_q     <= '0;
				time_q    <= '0;
				tbl_q     <= '0;
				rbi_q     <= '0;
				pc_q      <= '0;
				coding_q  <= '0;
				value_q   <= '0;
				flag_q    <= '0;
				ttime_q   <= '0;
				discard_q <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				len_q     <= len_n;
				fcode_q   <= fcode_n;
				src_q     <= src_n;
				dst_q     <= dst_n;
				cnt_q     <= cnt_n;
				time_q    <= time_n;
				tbl_q     <= tbl_n;
				rbi_q     <= rbi_n;
				pc_q      <= pc_n;
				coding_q  <= coding_n;
				value_q   <= value_n;
				flag_q    <= flag_n;
				ttime_q   <= ttime_n;
				discard_q <= discard_n;
			end
		end
	end

endmodule

FILE: hdl/trfd_out_fifo.sv
// ----------------------------------------------------------------------------
// trfd_out_fifo: result queue
// Four-entry queue that takes up to two results per cycle and hands out one
// per transfer.
// ----------------------------------------------------------------------------
module trfd_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  trfd_pkg::push_t     push,
	output logic                space,
	output logic                valid,
	input  logic                ready,
	output trfd_pkg::result_t   head
);

	trfd_pkg::result_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign space = (cnt_q <= 3'd2);
	assign valid = (cnt_q != 3'd0);
	assign pop   = valid && ready;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2)
			mem_q[wr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push.count) - 3'(pop);
		end
	end

endmodule

FILE: hdl/test_record_frame_deframer.sv
// ----------------------------------------------------------------------------
// test_record_frame_deframer: test record frame deframer
// Checks the sync word, extracts header fields and splits test records.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (data_valid/data_ready) carries one frame byte per
//   transfer, with frame_last high on the final byte of a frame.
//   Output channel (result_valid/result_ready) carries one result per
//   transfer: a header result after the table byte, one result per
//   completed test record, and a frame end result with status on the last
//   byte. Records come out before the length check; drop them on bad status.
//   Results enter the result queue at their byte transfer, behind older ones.
//   Throughput: one byte per cycle while data_ready is high. The last
//   byte of a frame can give two results; a four-entry result queue absorbs
//   them, and data_ready drops only while fewer than two queue slots are free.
//   Receiver stall: results wait in the queue; once fewer than two slots
//   are free, data_ready goes low until result_ready drains it.
//   Reset: arst_n clears parser state and empties the queue; data_ready is
//   high right after reset.
// ----------------------------------------------------------------------------
module test_record_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [7:0]  frame_id,
	output logic [7:0]  src_node,
	output logic [7:0]  dst_node,
	output logic [31:0] frame_count,
	output logic [31:0] time_stamp,
	output logic [7:0]  table_number,
	output logic [7:0]  coding,
	output logic [31:0] value,
	output logic [7:0]  pass_flag,
	output logic [31:0] test_stamp
);

	trfd_pkg::push_t   push;
	trfd_pkg::result_t head;
	logic              fire;

	assign fire = data_valid && data_ready;

	trfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_byte),
		.frame_last(frame_last),
		.push      (push)
	);

	trfd_out_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.space (data_ready),
		.valid (result_valid),
		.ready (result_ready),
		.head  (head)
	);

	assign kind         = head.kind;
	assign status       = head.status;
	assign frame_id     = head.frame_id;
	assign src_node     = head.src_node;
	assign dst_node     = head.dst_node;
	assign frame_count  = head.frame_count;
	assign time_stamp   = head.time_stamp;
	assign table_number = head.table_number;
	assign coding       = head.coding;
	assign value        = head.value;
	assign pass_flag    = head.pass_flag;
	assign test_stamp   = head.test_stamp;

endmodule

FILE: hdl/trfd_checker.sv
// ----------------------------------------------------------------------------
// trfd_checker: port checker
// Watches the deframer ports for output hold and queue consistency.
// ----------------------------------------------------------------------------
module trfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        data_valid,
	input logic        data_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  kind,
	input logic [1:0]  status,
	input logic [7:0]  coding,
	input logic [31:0] value,
	input logic [31:0] test_stamp
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped during stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(kind) && $stable(status)
			&& $stable(value) && $stable(test_stamp))
		else $error("result payload changed during stall");

	a_status_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != trfd_pkg::KIND_END |-> status == trfd_pkg::ST_OK)
		else $error("status set on non-end result");

	a_nonrec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != trfd_pkg::KIND_RECORD |-> coding == 8'd0
			&& value == 32'd0 && test_stamp == 32'd0)
		else $error("record fields set on header or end result");

	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!data_ready |-> result_valid)
		else $error("input stalled with empty result queue");

endmodule

bind test_record_frame_deframer trfd_checker u_trfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.data_valid  (data_valid),
	.data_ready  (data_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.kind        (kind),
	.status      (status),
	.coding      (coding),
	.value       (value),
	.test_stamp  (test_stamp)
);

FILE: verif/deframe_check.sv
// ----------------------------------------------------------------------------
// deframe_check: result predictor and comparator for the frame deframer
// Watches both channels. Every byte transfer is run through a local copy of
// the frame parser, which queues the header, record and frame end results
// it implies. Every result transfer is compared, field by field, with the
// oldest queued result.
// ----------------------------------------------------------------------------
module deframe_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	input  logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_last,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [1:0]  kind,
	input  logic [1:0]  status,
	input  logic [7:0]  frame_id,
	input  logic [7:0]  src_node,
	input  logic [7:0]  dst_node,
	input  logic [31:0] frame_count,
	input  logic [31:0] time_stamp,
	input  logic [7:0]  table_number,
	input  logic [7:0]  coding,
	input  logic [31:0] value,
	input  logic [7:0]  pass_flag,
	input  logic [31:0] test_stamp,
	output int          fails,
	output int          pending,
	output int          results,
	output int          records
);

	localparam int MAX_REPORTS = 40;

	logic [trfd_pkg::POS_W-1:0] pos;
	logic [15:0]      len_r;
	logic [7:0]       code_r;
	logic [7:0]       src_r;
	logic [7:0]       dst_r;
	logic [31:0]      cnt_r;
	logic [31:0]      stamp_r;
	logic [7:0]       tbl_r;
	logic             sync_bad;
	int               rec_idx;
	int               recs_done;
	logic [7:0]       rec_code;
	logic [31:0]      rec_val;
	logic [7:0]       rec_flag;
	logic [31:0]      rec_time;

	trfd_pkg::result_t due_results[$];

	function automatic int value_width(logic [7:0] t);
		case (t)
			8'd1, 8'd2: return 1;
			8'd3:       return 4;
			8'd4:       return 2;
			default:    return 0;
		endcase
	endfunction

	function automatic int record_quota();
		if (tbl_r < 8'd1 || tbl_r > 8'd4)
			return 1;
		if (len_r == 16'd0)
			return 0;
		return (int'(len_r) - 1) / (value_width(tbl_r) + 6);
	endfunction

	function automatic trfd_pkg::result_t snapshot(logic [1:0] k, logic [1:0] st,
						       logic [7:0] c, logic [31:0] v,
						       logic [7:0] f, logic [31:0] t);
		trfd_pkg::result_t r;
		r.kind         = k;
		r.status       = st;
		r.frame_id     = code_r;
		r.src_node     = src_r;
		r.dst_node     = dst_r;
		r.frame_count  = cnt_r;
		r.time_stamp   = stamp_r;
		r.table_number = tbl_r;
		r.coding       = c;
		r.value        = v;
		r.pass_flag    = f;
		r.test_stamp   = t;
		return r;
	endfunction

	task automatic clear_frame();
		pos       = '0;
		len_r     = '0;
		code_r    = '0;
		src_r     = '0;
		dst_r     = '0;
		cnt_r     = '0;
		stamp_r   = '0;
		tbl_r     = '0;
		sync_bad  = 1'b0;
		rec_idx   = 0;
		recs_done = 0;
		rec_code  = '0;
		rec_val   = '0;
		rec_flag  = '0;
		rec_time  = '0;
	endtask

	task automatic expect_result(trfd_pkg::result_t r);
		due_results.push_back(r);
		pending++;
	endtask

	task automatic take_byte(logic [7:0] d, logic last);
		logic [trfd_pkg::POS_W-1:0] p;
		logic [17:0]      total;
		logic [1:0]       st;
		int               vb;
		int               i;
		p = pos;
		if (p < trfd_pkg::POS_SYNC_END) begin
			if (d != (p[0] ? trfd_pkg::SYNC_ODD : trfd_pkg::SYNC_EVEN))
				sync_bad = 1'b1;
		end else if (p == trfd_pkg::POS_CODE) begin
			code_r = d;
		end else if (p == trfd_pkg::POS_LEN_LO) begin
			len_r[7:0] = d;
		end else if (p == trfd_pkg::POS_LEN_HI) begin
			len_r[15:8] = d;
		end else if (p == trfd_pkg::POS_SRC) begin
			src_r = d;
		end else if (p == trfd_pkg::POS_DST) begin
			dst_r = d;
		end else if (p <= trfd_pkg::POS_CNT_END) begin
			cnt_r[8*(int'(p) - int'(trfd_pkg::POS_DST) - 1) +: 8] = d;
		end else if (p <= trfd_pkg::POS_TIME_END) begin
			stamp_r[8*(int'(p) - int'(trfd_pkg::POS_CNT_END) - 1) +: 8] = d;
		end else if (p == trfd_pkg::POS_TABLE) begin
			tbl_r = d;
			if (!sync_bad)
				expect_result(snapshot(trfd_pkg::KIND_HEADER, trfd_pkg::ST_OK,
						       '0, '0, '0, '0));
		end else if (!sync_bad && recs_done < record_quota()) begin
			vb = value_width(tbl_r);
			i  = rec_idx;
			if (i == 0) begin
				rec_code = d;
				rec_val  = '0;
				rec_flag = '0;
				rec_time = '0;
			end else if (i <= vb) begin
				rec_val[8*(i-1) +: 8] = d;
			end else if (i == vb + 1) begin
				rec_flag = d;
			end else begin
				rec_time[8*(i-vb-2) +: 8] = d;
			end
			if (i >= vb + 5) begin
				expect_result(snapshot(trfd_pkg::KIND_RECORD, trfd_pkg::ST_OK,
						       rec_code, rec_val, rec_flag, rec_time));
				recs_done++;
				rec_idx = 0;
			end else begin
				rec_idx = i + 1;
			end
		end

		if (last) begin
			total = {1'b0, p} + 18'd1;
			if (sync_bad)
				st = trfd_pkg::ST_SYNC;
			else if (total <= 18'(trfd_pkg::POS_TABLE))
				st = trfd_pkg::ST_SHORT;
			else if (total != {2'b00, len_r} + trfd_pkg::LEN_OVERHEAD)
				st = trfd_pkg::ST_LENGTH;
			else
				st = trfd_pkg::ST_OK;
			expect_result(snapshot(trfd_pkg::KIND_END, st, '0, '0, '0, '0));
			clear_frame();
		end else if (p != trfd_pkg::POS_MAX) begin
			pos = p + 1'b1;
		end
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t mismatch in %s: expected %h, actual %h",
					 $time, name, want, got);
		end
	endtask

	task automatic check_result();
		trfd_pkg::result_t want;
		results++;
		if (due_results.size() == 0) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t unexpected result: expected none, actual kind %0d status %0d",
					 $time, kind, status);
		end else begin
			want = due_results.pop_front();
			pending--;
			if (want.kind == trfd_pkg::KIND_RECORD)
				records++;
			compare_field("kind",         want.kind,         kind);
			compare_field("status",       want.status,       status);
			compare_field("frame_id",     want.frame_id,     frame_id);
			compare_field("src_node",     want.src_node,     src_node);
			compare_field("dst_node",     want.dst_node,     dst_node);
			compare_field("frame_count",  want.frame_count,  frame_count);
			compare_field("time_stamp",   want.time_stamp,   time_stamp);
			compare_field("table_number", want.table_number, table_number);
			compare_field("coding",       want.coding,       coding);
			compare_field("value",        want.value,        value);
			compare_field("pass_flag",    want.pass_flag,    pass_flag);
			compare_field("test_stamp",   want.test_stamp,   test_stamp);
		end
	endtask

	// results are registered in the queue behind their byte, so compare before predicting
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			due_results.delete();
			fails   = 0;
			pending = 0;
			results = 0;
			records = 0;
		end else begin
			if (result_valid === 1'b1 && result_ready)
				check_result();
			if (data_valid && data_ready === 1'b1)
				take_byte(data_byte, frame_last);
		end
	end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the test record frame deframer
// Feeds directed frames (every table layout, sync errors at each position,
// short, truncated, zero length) and then random frames, mostly well
// formed, some with trailing bytes, under three flow-control mixes, with a
// long receiver hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_BYTES  = 270;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int NO_SYNC_ERR  = -1;

	localparam int FILL_RAND = 0;
	localparam int FILL_ZERO = 1;
	localparam int FILL_ONES = 2;

	localparam int MIX_SLOW_SINK   = 0;
	localparam int MIX_SLOW_SOURCE = 1;
	localparam int MIX_FREE        = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        data_valid;
	logic        data_ready;
	logic [7:0]  data_byte;
	logic        frame_last;
	logic        result_valid;
	logic        result_ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [7:0]  frame_id;
	logic [7:0]  src_node;
	logic [7:0]  dst_node;
	logic [31:0] frame_count;
	logic [31:0] time_stamp;
	logic [7:0]  table_number;
	logic [7:0]  coding;
	logic [31:0] value;
	logic [7:0]  pass_flag;
	logic [31:0] test_stamp;

	int fails;
	int pending;
	int results;
	int records;

	int flow_mix = MIX_SLOW_SINK;
	bit hold_req = 1'b0;
	int frames_sent = 0;
	int bytes_sent = 0;
	int cycles = 0;

	test_record_frame_deframer dut (.*);

	deframe_check u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit source_idles();
		case (flow_mix)
			MIX_SLOW_SINK:   return $urandom_range(99) < 38;
			MIX_SLOW_SOURCE: return $urandom_range(99) < 64;
			default:         return 1'b0;
		endcase
	endfunction

	function automatic bit sink_idles();
		case (flow_mix)
			MIX_SLOW_SINK:   return $urandom_range(99) < 64;
			MIX_SLOW_SOURCE: return $urandom_range(99) < 38;
			default:         return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] filler(int fill);
		case (fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'($urandom_range(255));
		endcase
	endfunction

	// receiver: random stalls, or a long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			result_ready = !sink_idles();
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_byte(logic [7:0] b, logic l);
		while (source_idles()) begin
			data_valid = 1'b0;
			@(negedge clk);
		end
		data_valid = 1'b1;
		data_byte  = b;
		frame_last = l;
		@(posedge clk);
		while (data_ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(logic [15:0] len, logic [7:0] tbl, int total,
				  int bad_sync, int fill);
		logic [7:0] b;
		for (int k = 0; k < total; k++) begin
			if (k < int'(trfd_pkg::POS_SYNC_END)) begin
				b = k[0] ? trfd_pkg::SYNC_ODD : trfd_pkg::SYNC_EVEN;
				if (k == bad_sync)
					b = b ^ 8'($urandom_range(1, 255));
			end else if (k == int'(trfd_pkg::POS_LEN_LO)) begin
				b = len[7:0];
			end else if (k == int'(trfd_pkg::POS_LEN_HI)) begin
				b = len[15:8];
			end else if (k == int'(trfd_pkg::POS_TABLE)) begin
				b = tbl;
			end else begin
				b = filler(fill);
			end
			send_byte(b, k == total - 1);
		end
		frames_sent++;
	endtask

	task automatic random_frame();
		logic [7:0]  tbl;
		logic [15:0] len;
		int          size;
		int          total;
		int          bad;
		int          sel;
		if ($urandom_range(99) < 85)
			tbl = 8'($urandom_range(1, 4));
		else
			tbl = 8'($urandom_range(255));
		case (tbl)
			8'd1, 8'd2: size = 7;
			8'd3:       size = 10;
			8'd4:       size = 8;
			default:    size = 6;
		endcase
		if (size == 6)
			len = 16'($urandom_range(0, 12));
		else if ($urandom_range(9) == 0)
			len = 16'd0;
		else
			len = 16'($urandom_range(0, 3) * size + 1 + $urandom_range(0, size - 1));
		total = int'(len) + int'(trfd_pkg::LEN_OVERHEAD);
		sel = $urandom_range(99);
		if (sel < 8) begin
			total = $urandom_range(1, int'(trfd_pkg::POS_TABLE));
		end else if (sel < 16) begin
			total = $urandom_range(int'(trfd_pkg::POS_TABLE) + 1, int'(len) + 30);
		end else if (sel < 22) begin
			len   = 16'($urandom_range(0, 16'hFFFF));
			total = $urandom_range(int'(trfd_pkg::POS_TABLE) + 1, 80);
		end
		bad = ($urandom_range(19) == 0) ? $urandom_range(0, 3) : NO_SYNC_ERR;
		send_frame(len, tbl, total, bad, FILL_RAND);
	endtask

	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int waited;
		arst_n     = 1'b0;
		data_valid = 1'b0;
		data_byte  = 8'h00;
		frame_last = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed frames
		send_frame(16'd15, 8'd1, 36, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd8,  8'd2, 29, NO_SYNC_ERR, FILL_ZERO);
		send_frame(16'd21, 8'd3, 42, NO_SYNC_ERR, FILL_ONES);
		send_frame(16'd9,  8'd4, 30, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd6,  8'd0, 27, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd3,  8'hFF, 24, NO_SYNC_ERR, FILL_ONES);
		send_frame(16'd0,  8'd1, 21, NO_SYNC_ERR, FILL_RAND);
		for (int s = 0; s < 4; s++)
			send_frame(16'd15, 8'd1, 36, s, FILL_RAND);
		send_frame(16'd15, 8'd1, 1,  NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd15, 8'd1, 17, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd15, 8'd1, 18, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd15, 8'd1, 3,  2, FILL_RAND);
		send_frame(16'd31, 8'd3, 33, NO_SYNC_ERR, FILL_RAND);
		send_frame(16'd20, 8'd4, 41, NO_SYNC_ERR, FILL_RAND);

		while (bytes_sent < PHASE_BYTES)
			random_frame();
		data_valid = 1'b0;
		wait_drained();

		flow_mix = MIX_SLOW_SOURCE;
		while (bytes_sent < 2 * PHASE_BYTES)
			random_frame();
		data_valid = 1'b0;
		wait_drained();

		// receiver holds off while a record-heavy frame keeps coming
		flow_mix = MIX_FREE;
		hold_req = 1'b1;
		send_frame(16'd200, 8'd1, 221, NO_SYNC_ERR, FILL_RAND);
		while (bytes_sent < 3 * PHASE_BYTES)
			random_frame();
		data_valid = 1'b0;
		frame_last = 1'b0;

		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (16) @(negedge clk);
		if (pending != 0)
			$display("%0t %0d expected results never arrived", $time, pending);

		$display("Sent %0d frames in %0d bytes under three flow-control mixes",
			 frames_sent, bytes_sent);
		$display("Checked %0d results, %0d of them test records", results, records);
		if (fails == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
